// ===== hw/rtl/quadratic_root_solver_assert.svh =====
// Assertion macros for the quadratic root solver.
// Used at the end of the top level; expects clk and rst_n in scope.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quadratic root solver check failed");

// Next-cycle implication, checked outside reset.
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quadratic root solver check failed");

`endif

// ===== hw/rtl/qrs_pkg.sv =====
// Shared constants and widths for the quadratic root solver.
// No dependencies.
package qrs_pkg;
  localparam int COEF_W    = 16;
  localparam int ROOT_W    = 35;
  localparam int SQ_STEPS  = 36;
  localparam int SQ_REM_W  = 39;
  localparam int RAD_W     = 40;
  localparam int RAD_STEPS = RAD_W / 2;
  localparam int DEN_W     = 17;
  localparam int DIV_STEPS = 35;

  typedef logic [1:0] status_t;
  localparam status_t ST_NONE  = 2'd0;
  localparam status_t ST_ONE   = 2'd1;
  localparam status_t ST_TWO   = 2'd2;
  localparam status_t ST_AZERO = 2'd3;
endpackage

// ===== hw/rtl/qrs_ifs.sv =====
// Valid/ready channel interfaces for coefficient words and root words.
// Depends on qrs_pkg.
interface qrs_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [qrs_pkg::COEF_W-1:0]       coef_a;
  logic signed [qrs_pkg::COEF_W-1:0]       coef_b;
  logic signed [qrs_pkg::COEF_W-1:0]       coef_c;
  modport source(output valid, coef_a, coef_b, coef_c, input ready);
  modport sink(input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
  logic                                    valid;
  logic                                    ready;
  qrs_pkg::status_t                        root_status;
  logic signed [qrs_pkg::ROOT_W-1:0]       root_one;
  logic signed [qrs_pkg::ROOT_W-1:0]       root_two;
  modport source(output valid, root_status, root_one, root_two, input ready);
  modport sink(input valid, root_status, root_one, root_two, output ready);
endinterface

// ===== hw/rtl/quadratic_root_solver.sv =====
// Quadratic root solver: discriminant, pipelined square root, two pipelined dividers.
// Depends on qrs_pkg, qrs_ifs and quadratic_root_solver_assert.svh.
//
//   channel  dir  payload                                 handshake
//   in_ch    in   coef_a, coef_b, coef_c                  valid/ready
//   out_ch   out  root_status, root_one, root_two         valid/ready
//
// One word enters per cycle while the pipeline advances; the stages are capture, products,
// discriminant, 36 square-root stages, numerator, 35 divide stages, output.
// The whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage and nothing is lost or repeated.
// Reset (rst_n, synchronous) clears only the valid bits.
module quadratic_root_solver (
  input  logic      clk,
  input  logic      rst_n,
  qrs_in_if.sink    in_ch,
  qrs_out_if.source out_ch
);
  import qrs_pkg::*;

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 0: capture.
  logic                     v0_r;
  logic signed [COEF_W-1:0] a0_r, b0_r, c0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
    end
    if (adv) begin
      a0_r <= in_ch.coef_a;
      b0_r <= in_ch.coef_b;
      c0_r <= in_ch.coef_c;
    end
  end

  // Stage 1: products.
  logic                v1_r, az1_r;
  logic signed [31:0]  bb1_r, ac1_r;
  logic signed [33:0]  nb1_r;
  logic signed [17:0]  den1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
    if (adv) begin
      bb1_r  <= b0_r * b0_r;
      ac1_r  <= a0_r * c0_r;
      nb1_r  <= -(34'(b0_r) <<< 16);
      den1_r <= 18'(a0_r) <<< 1;
      az1_r  <= (a0_r == '0);
    end
  end

  // Stage 2 feeds the square-root pipeline at index 0.
  logic                 sq_v_r   [0:SQ_STEPS];
  status_t              sq_st_r  [0:SQ_STEPS];
  logic signed [33:0]   sq_nb_r  [0:SQ_STEPS];
  logic signed [17:0]   sq_den_r [0:SQ_STEPS];
  logic [RAD_W-1:0]     sq_rad_r [0:SQ_STEPS];
  logic [SQ_REM_W-1:0]  sq_rem_r [0:SQ_STEPS];
  logic [SQ_STEPS-1:0]  sq_root_r[0:SQ_STEPS];

  logic signed [34:0] d_nxt;
  status_t            st_nxt;

  always_comb begin
    d_nxt = 35'(bb1_r) - (35'(ac1_r) <<< 2);
    if (az1_r) begin
      st_nxt = ST_AZERO;
    end else if (d_nxt < 0) begin
      st_nxt = ST_NONE;
    end else if (d_nxt == '0) begin
      st_nxt = ST_ONE;
    end else begin
      st_nxt = ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v1_r;
    end
    if (adv) begin
      sq_st_r[0]   <= st_nxt;
      sq_nb_r[0]   <= nb1_r;
      sq_den_r[0]  <= den1_r;
      sq_rad_r[0]  <= {6'd0, d_nxt[33:0]};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  // Digit-by-digit square root of D * 2^32, one result bit per stage.
  // The low 32 radicand bits are zero, so later stages shift in zero pairs.
  genvar k;
  generate
    for (k = 0; k < SQ_STEPS; k++) begin : g_sq
      logic [1:0]          pair;
      logic [SQ_REM_W-1:0] ri, tr;
      logic                ge;
      if (k < RAD_STEPS) begin : g_pair
        assign pair = sq_rad_r[k][RAD_W-1-2*k -: 2];
      end else begin : g_zero
        assign pair = 2'b00;
      end
      assign ri = {sq_rem_r[k][SQ_REM_W-3:0], pair};
      assign tr = {1'b0, sq_root_r[k], 2'b01};
      assign ge = (ri >= tr);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sq_v_r[k+1] <= 1'b0;
        end else if (adv) begin
          sq_v_r[k+1] <= sq_v_r[k];
        end
        if (adv) begin
          sq_st_r[k+1]   <= sq_st_r[k];
          sq_nb_r[k+1]   <= sq_nb_r[k];
          sq_den_r[k+1]  <= sq_den_r[k];
          sq_rad_r[k+1]  <= sq_rad_r[k];
          sq_rem_r[k+1]  <= ge ? (ri - tr) : ri;
          sq_root_r[k+1] <= {sq_root_r[k][SQ_STEPS-2:0], ge};
        end
      end
    end
  endgenerate

  // Numerator stage: signed numerators, then magnitudes and quotient signs.
  logic                 dv_v_r   [0:DIV_STEPS];
  status_t              dv_st_r  [0:DIV_STEPS];
  logic [DEN_W-1:0]     dv_dvs_r [0:DIV_STEPS];
  logic                 dv_ng1_r [0:DIV_STEPS];
  logic                 dv_ng2_r [0:DIV_STEPS];
  logic [ROOT_W-1:0]    dv_m1_r  [0:DIV_STEPS];
  logic [ROOT_W-1:0]    dv_m2_r  [0:DIV_STEPS];
  logic [DEN_W:0]       dv_r1_r  [0:DIV_STEPS];
  logic [DEN_W:0]       dv_r2_r  [0:DIV_STEPS];
  logic [ROOT_W-1:0]    dv_q1_r  [0:DIV_STEPS];
  logic [ROOT_W-1:0]    dv_q2_r  [0:DIV_STEPS];

  logic signed [35:0] n1, n2, sx;
  logic signed [17:0] dn;
  logic [35:0]        m1, m2;
  logic [17:0]        dm;

  always_comb begin
    sx = {1'b0, sq_root_r[SQ_STEPS][34:0]};
    n1 = 36'(sq_nb_r[SQ_STEPS]) + sx;
    n2 = 36'(sq_nb_r[SQ_STEPS]) - sx;
    dn = sq_den_r[SQ_STEPS];
    m1 = n1[35] ? 36'(-n1) : 36'(n1);
    m2 = n2[35] ? 36'(-n2) : 36'(n2);
    dm = dn[17] ? 18'(-dn) : 18'(dn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQ_STEPS];
    end
    if (adv) begin
      dv_st_r[0]  <= sq_st_r[SQ_STEPS];
      dv_dvs_r[0] <= dm[DEN_W-1:0];
      dv_ng1_r[0] <= n1[35] ^ dn[17];
      dv_ng2_r[0] <= n2[35] ^ dn[17];
      dv_m1_r[0]  <= m1[ROOT_W-1:0];
      dv_m2_r[0]  <= m2[ROOT_W-1:0];
      dv_r1_r[0]  <= '0;
      dv_r2_r[0]  <= '0;
      dv_q1_r[0]  <= '0;
      dv_q2_r[0]  <= '0;
    end
  end

  // Restoring division of both magnitudes by |2a|, one quotient bit per stage.
  genvar j;
  generate
    for (j = 0; j < DIV_STEPS; j++) begin : g_dv
      logic [DEN_W:0] ri1, ri2, dd;
      logic           ge1, ge2;
      assign dd  = {1'b0, dv_dvs_r[j]};
      assign ri1 = {dv_r1_r[j][DEN_W-1:0], dv_m1_r[j][ROOT_W-1-j]};
      assign ri2 = {dv_r2_r[j][DEN_W-1:0], dv_m2_r[j][ROOT_W-1-j]};
      assign ge1 = (ri1 >= dd);
      assign ge2 = (ri2 >= dd);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_v_r[j+1] <= 1'b0;
        end else if (adv) begin
          dv_v_r[j+1] <= dv_v_r[j];
        end
        if (adv) begin
          dv_st_r[j+1]  <= dv_st_r[j];
          dv_dvs_r[j+1] <= dv_dvs_r[j];
          dv_ng1_r[j+1] <= dv_ng1_r[j];
          dv_ng2_r[j+1] <= dv_ng2_r[j];
          dv_m1_r[j+1]  <= dv_m1_r[j];
          dv_m2_r[j+1]  <= dv_m2_r[j];
          dv_r1_r[j+1]  <= ge1 ? (ri1 - dd) : ri1;
          dv_r2_r[j+1]  <= ge2 ? (ri2 - dd) : ri2;
          dv_q1_r[j+1]  <= {dv_q1_r[j][ROOT_W-2:0], ge1};
          dv_q2_r[j+1]  <= {dv_q2_r[j][ROOT_W-2:0], ge2};
        end
      end
    end
  endgenerate

  // Output register: apply signs and zero the fields the status leaves unused.
  logic              out_v_r;
  status_t           out_st_r;
  logic [ROOT_W-1:0] out_r1_r, out_r2_r;
  logic [ROOT_W-1:0] q1s, q2s;
  status_t           fst;

  always_comb begin
    fst = dv_st_r[DIV_STEPS];
    q1s = dv_ng1_r[DIV_STEPS] ? ROOT_W'(-dv_q1_r[DIV_STEPS]) : dv_q1_r[DIV_STEPS];
    q2s = dv_ng2_r[DIV_STEPS] ? ROOT_W'(-dv_q2_r[DIV_STEPS]) : dv_q2_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[DIV_STEPS];
    end
    if (adv) begin
      out_st_r <= fst;
      out_r1_r <= (fst == ST_ONE || fst == ST_TWO) ? q1s : '0;
      out_r2_r <= (fst == ST_TWO) ? q2s : '0;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.root_status = out_st_r;
  assign out_ch.root_one    = out_r1_r;
  assign out_ch.root_two    = out_r2_r;

`include "quadratic_root_solver_assert.svh"

  `QRS_ASSERT_NOW(a_two_only, out_v_r && out_st_r != ST_TWO, out_r2_r == '0)
  `QRS_ASSERT_NOW(a_none_zero, out_v_r && (out_st_r == ST_NONE || out_st_r == ST_AZERO), out_r1_r == '0)
  `QRS_ASSERT_NEXT(a_freeze, !adv, $stable(dv_v_r[0]) && $stable(sq_v_r[0]))
endmodule

// ===== sim/qrs_tb_ifs.sv =====
// Testbench-side helpers for the quadratic root solver channels.
// Depends on qrs_pkg; the channel interfaces themselves come from qrs_ifs.
package qrs_tb_pkg;
  import qrs_pkg::*;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_word_t;

  typedef struct packed {
    status_t                  status;
    logic signed [ROOT_W-1:0] r1;
    logic signed [ROOT_W-1:0] r2;
  } root_word_t;
endpackage

// ===== sim/quadratic_root_solver_tb.sv =====
// Self-checking testbench for quadratic_root_solver: streams coefficient words,
// predicts each root word in fixed point and compares in order.
// Depends on qrs_pkg, qrs_ifs, qrs_tb_ifs and the solver RTL.
module quadratic_root_solver_tb;
  import qrs_pkg::*;
  import qrs_tb_pkg::*;

  localparam int LATENCY = 76;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  qrs_in_if  in_ch();
  qrs_out_if out_ch();

  quadratic_root_solver dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  coef_word_t pending_coefs[$];
  root_word_t expected_roots[$];
  int errors = 0;
  longint cycle_count = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  bit in_taken = 1'b0;
  int send_gap = 0;
  int take_gap = 0;

  // Integer square root of d * 2^32, truncated.
  function automatic logic [35:0] isqrt_q16(logic [63:0] d);
    logic [99:0] v;
    logic [35:0] r;
    logic [35:0] cand;
    v = {4'd0, d, 32'd0};
    r = '0;
    for (int i = 35; i >= 0; i--) begin
      cand = r | (36'd1 << i);
      if ({64'd0, cand} * {64'd0, cand} <= v) r = cand;
    end
    return r;
  endfunction

  function automatic root_word_t solve_roots(coef_word_t w);
    root_word_t res;
    longint a, b, c, d, den, nb, s;
    a = w.a;
    b = w.b;
    c = w.c;
    res = '0;
    if (a == 0) begin
      res.status = ST_AZERO;
    end else begin
      d = b * b - 4 * a * c;
      den = 2 * a;
      nb = -b * 65536;
      if (d < 0) begin
        res.status = ST_NONE;
      end else if (d == 0) begin
        res.status = ST_ONE;
        res.r1 = ROOT_W'(nb / den);
      end else begin
        s = longint'(isqrt_q16(d));
        res.status = ST_TWO;
        res.r1 = ROOT_W'((nb + s) / den);
        res.r2 = ROOT_W'((nb - s) / den);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'(int'($urandom_range(0, 6)) - 3);
      1: return 16'(int'($urandom_range(0, 200)) - 100);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    pending_coefs.push_back(coef_word_t'{a: a, b: b, c: c});
  endtask

  // Driver: the word at the head of the queue is presented at the falling edge
  // and held until it is taken; it leaves the queue once taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the current word.
    end else begin
      if (in_ch.valid) void'(pending_coefs.pop_front());
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 3);
        in_ch.valid <= 1'b0;
      end else if (pending_coefs.size() > 0) begin
        in_ch.valid  <= 1'b1;
        in_ch.coef_a <= pending_coefs[0].a;
        in_ch.coef_b <= pending_coefs[0].b;
        in_ch.coef_c <= pending_coefs[0].c;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Record the prediction at the accepting edge.
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_roots.push_back(solve_roots(coef_word_t'{a: in_ch.coef_a, b: in_ch.coef_b,
                                                        c: in_ch.coef_c}));
  end

  // Receiver readiness.
  always @(negedge clk) begin
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      take_gap = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    root_word_t want;
    cycle_count++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_roots.pop_front();
        if (out_ch.root_status !== want.status)
          report_mismatch("root_status", out_ch.root_status, want.status);
        if (out_ch.root_one !== want.r1)
          report_mismatch("root_one", out_ch.root_one, want.r1);
        if (out_ch.root_two !== want.r2)
          report_mismatch("root_two", out_ch.root_two, want.r2);
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Long receiver stall so the pipeline fills and backs up the input.
  initial begin
    wait (rst_n);
    wait (pending_coefs.size() > 0 && in_ch.valid);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    out_ch.ready = 1'b0;
    // Directed words: zero a, extremes, no root, one root, two roots.
    push_coefs(0, 0, 0);
    push_coefs(0, 16'h7fff, 16'h8000);
    push_coefs(1, 0, 1);
    push_coefs(1, 2, 1);
    push_coefs(16'hffff, 2, 16'hffff);
    push_coefs(1, 0, 16'hffff);
    push_coefs(1, 16'h8000, 16'h8000);
    push_coefs(16'h8000, 16'h8000, 16'h7fff);
    push_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    push_coefs(16'h8000, 16'h7fff, 16'h8000);
    push_coefs(16'h7fff, 16'h8000, 16'h8000);
    push_coefs(1, 16'h8000, 0);
    push_coefs(16'hffff, 16'h7fff, 16'h7fff);
    push_coefs(2, 16'hfffd, 1);
    push_coefs(16'hffff, 16'hffff, 16'hffff);
    push_coefs(3, 16'hfff6, 3);
    for (int i = 0; i < 1750; i++) begin
      logic [15:0] a, b, k;
      a = rand_coef();
      b = rand_coef();
      // About a sixth of the words are built with a zero discriminant to hit
      // the single root.
      if (i % 3 == 0 && $urandom_range(0, 1)) begin
        k = 16'(int'($urandom_range(0, 362)) - 181);
        push_coefs(1, 16'($signed(k) * 2), 16'($signed(k) * $signed(k)));
      end else begin
        push_coefs(a, b, rand_coef());
      end
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_coefs.size() < 200);
    calm = 1'b1;
    wait (pending_coefs.size() == 0);
    wait (expected_roots.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
